[hdl/bctm_pkg.sv]
// ----------------------------------------------------------------------------
// bctm_pkg
// Shared types and constants for the block cache tag manager.
// ----------------------------------------------------------------------------
package bctm_pkg;

    localparam int BLOCK_W    = 32;
    localparam int SLOT_W     = 5;
    localparam int SECTOR_W   = 39;
    localparam int BSL_W      = 3;

    // operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [BLOCK_W-1:0] block_number;
    } bctm_in_t;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot_index;
        logic                fill_needed;
        logic                evicted;
        logic [SECTOR_W-1:0] sector_address;
    } bctm_out_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // take the request and register the tag compare
        logic update;   // resolve slot, write tag store, load result register
    } bctm_cmd_t;

endpackage

[hdl/block_cache_tag_manager_core.sv]
// ----------------------------------------------------------------------------
// block_cache_tag_manager_core
// Fully associative tag manager for a disk block cache, round-robin refill.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries requests (read lookup with fill, or write invalidate)
//   with a block number; m_* channel returns one result transaction per
//   request: hit, slot, fill/evict flags and the 512-byte sector address.
//   cfg_wr_en/cfg_wr_data set block_size_log; write it only while idle.
// Sequence:
//   When a request is accepted, tags are compared in parallel into registered
//   match/empty vectors; slot pick and tag update follow in the update step,
//   which loads the result register. A new request is not accepted until the
//   previous one has left the update step (compare -> pick/update sequence).
// Stall:
//   The result sits in an output register; if m_ready is low, the next
//   request is still accepted and compared, and waits in the update step
//   until the output register frees up.
// Reset:
//   aresetn (sync, active low) empties all tags, zeroes the replace pointer
//   and block_size_log, and drops m_valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module block_cache_tag_manager_core #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bctm_pkg::bctm_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bctm_pkg::bctm_out_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [bctm_pkg::BSL_W-1:0]    cfg_wr_data
);
    import bctm_pkg::*;

    bctm_cmd_t cmd;

    // sequencer: owns handshakes and the result-valid flag
    bctm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // tag registers, compare, pick and result register
    bctm_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_data      (m_data)
    );

endmodule

[hdl/bctm_ctrl.sv]
// ----------------------------------------------------------------------------
// bctm_ctrl
// Request sequencer: accept, resolve, hand the result to the output register.
// ----------------------------------------------------------------------------
module bctm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output bctm_pkg::bctm_cmd_t cmd
);
    import bctm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_UPD  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign cmd.capture = s_valid && s_ready;
    // result register must be free (or draining this cycle)
    assign cmd.update  = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) state_next = ST_UPD;
            end
            ST_UPD: begin
                if (cmd.update) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.update)   m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hdl/bctm_datapath.sv]
// ----------------------------------------------------------------------------
// bctm_datapath
// Tag registers, parallel compare, slot pick, round-robin pointer, result reg.
// ----------------------------------------------------------------------------
module bctm_datapath #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bctm_pkg::bctm_cmd_t           cmd,
    input  bctm_pkg::bctm_in_t            s_data,
    input  logic                          cfg_wr_en,
    input  logic [bctm_pkg::BSL_W-1:0]    cfg_wr_data,
    output bctm_pkg::bctm_out_t           m_data
);
    import bctm_pkg::*;

    localparam int PTR_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int IDX_W = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(NUM_ENTRIES - 1);

    logic [BLOCK_W-1:0]     tag_reg [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] match_reg, match_next;
    logic [NUM_ENTRIES-1:0] empty_reg, empty_next;
    logic                   op_reg;
    logic [BLOCK_W-1:0]     blk_reg;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [BSL_W-1:0]       bsl_reg;
    bctm_out_t              out_reg, out_next;

    logic [PTR_W-1:0]       match_idx, empty_idx, slot;
    logic                   tag_wr_en;
    logic [PTR_W-1:0]       tag_wr_idx;
    logic [BLOCK_W-1:0]     tag_wr_val;
    logic [IDX_W-1:0]       slot_wide;
    logic [SECTOR_W-1:0]    blk_ext;

    // parallel compare against the incoming block number
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            match_next[i] = (tag_reg[i] == s_data.block_number);
            empty_next[i] = (tag_reg[i] == '0);
        end
    end

    // lowest match, highest empty
    always_comb begin
        match_idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (match_reg[i]) match_idx = PTR_W'(i);
        end
        empty_idx = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (empty_reg[i]) empty_idx = PTR_W'(i);
        end
    end

    assign blk_ext = SECTOR_W'(blk_reg);

    always_comb begin
        ptr_next   = ptr_reg;
        tag_wr_en  = 1'b0;
        tag_wr_val = blk_reg;
        slot       = '0;
        out_next   = out_reg;
        out_next.hit         = 1'b0;
        out_next.fill_needed = 1'b0;
        out_next.evicted     = 1'b0;
        if (op_reg == OP_READ) begin
            if (|match_reg) begin
                slot         = match_idx;
                out_next.hit = 1'b1;
            end else begin
                out_next.fill_needed = 1'b1;
                tag_wr_en            = 1'b1;
                if (|empty_reg) begin
                    slot = empty_idx;
                end else begin
                    slot             = ptr_reg;
                    out_next.evicted = 1'b1;
                    ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                end
            end
        end else begin
            tag_wr_val = '0;
            if (|match_reg) begin
                slot         = match_idx;
                out_next.hit = 1'b1;
                tag_wr_en    = 1'b1;
            end
        end
        slot_wide               = IDX_W'(slot);
        out_next.slot_index     = slot_wide[SLOT_W-1:0];
        out_next.sector_address = blk_ext << ({1'b0, bsl_reg} + 4'd1);
        tag_wr_idx              = slot;
    end

    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ENTRIES; i++) tag_reg[i] <= '0;
            ptr_reg <= '0;
            bsl_reg <= '0;
        end else begin
            if (cmd.update && tag_wr_en) begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (tag_wr_idx == PTR_W'(i)) tag_reg[i] <= tag_wr_val;
                end
            end
            if (cmd.update) ptr_reg <= ptr_next;
            if (cfg_wr_en)  bsl_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            match_reg <= match_next;
            empty_reg <= empty_next;
            op_reg    <= s_data.operation;
            blk_reg   <= s_data.block_number;
        end
        if (cmd.update) out_reg <= out_next;
    end

endmodule
